### hdl/mcpa_pkg.sv
// Shared constants, register codes and modular add/subtract helpers for
// the Montgomery curve point adder. No dependencies.
package mcpa_pkg;

    localparam int FIELD_BITS_DEF = 64;
    localparam int MAX_BITS       = 64;
    localparam int A_BITS         = 48;
    localparam int CFG_IDX_BITS   = 1;
    localparam int CFG_DATA_BITS  = 64;

    typedef logic [MAX_BITS-1:0] t_word;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_A  = 1'b1;

    localparam logic [MAX_BITS-1:0] MODULUS_RST = 64'hFFFF_FFFF_FFFF_FFC5;
    localparam logic [A_BITS-1:0]   COEF_A_RST  = 48'd486662;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOINV   = 2'd1;
    localparam logic [1:0] ST_NOTCONJ = 2'd2;

    // (a + b) mod m for a, b < m
    function automatic t_word madd(t_word a, t_word b, t_word m);
        logic [MAX_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[MAX_BITS-1:0];
    endfunction

    // (a - b) mod m for a, b < m; wraps through the word width
    function automatic t_word msub(t_word a, t_word b, t_word m);
        t_word d;
        d = a - b;
        if (a < b) begin
            d = d + m;
        end
        return d;
    endfunction

endpackage

### hdl/mcpa_div.sv
// Restoring bit-serial divider: one quotient bit per cycle.
// Depends on mcpa_pkg.
module mcpa_div #(
    parameter int DW = mcpa_pkg::FIELD_BITS_DEF,
    parameter int VW = mcpa_pkg::FIELD_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_num,
    input  logic [VW-1:0] i_den,
    output logic          o_done,
    output logic [DW-1:0] o_quo,
    output logic [VW-1:0] o_rem
);
    import mcpa_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic          r_run;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_q;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_den;
    logic [VW:0]   n_trial;
    logic          n_ge;

    assign n_trial = {r_rem, r_q[DW-1]};
    assign n_ge    = n_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CW'(DW);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out of the top while quotient bits shift in below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_run) begin
            r_q   <= {r_q[DW-2:0], n_ge};
            r_rem <= n_ge ? VW'(n_trial - {1'b0, r_den}) : VW'(n_trial);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_rem;

endmodule

### hdl/mcpa_mul.sv
// Bit-serial modular multiplier: double, then conditionally add, per bit.
// Depends on mcpa_pkg.
module mcpa_mul #(
    parameter int W = mcpa_pkg::FIELD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_m,
    output logic         o_done,
    output logic [W-1:0] o_prod
);
    import mcpa_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic          r_run;
    logic          r_done;
    logic          r_phase;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_a;
    logic [W-1:0]  r_b;
    logic [W-1:0]  r_m;
    logic [W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run   <= 1'b1;
                r_phase <= 1'b0;
                r_cnt   <= CW'(W);
            end else if (r_run) begin
                r_phase <= !r_phase;
                if (r_phase) begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_run  <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_m   <= i_m;
            r_acc <= '0;
        end else if (r_run) begin
            if (!r_phase) begin
                r_acc <= W'(madd(t_word'(r_acc), t_word'(r_acc), t_word'(r_m)));
            end else begin
                if (r_b[W-1]) begin
                    r_acc <= W'(madd(t_word'(r_acc), t_word'(r_a), t_word'(r_m)));
                end
                r_b <= {r_b[W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

### hdl/montgomery_curve_point_add.sv
// Montgomery curve affine point adder: sequencer around mcpa_div and mcpa_mul.
// Sequence: the coefficient and the four coordinates are reduced mod m with
// the divider; each Euclid round is one divide, one multiply and an update;
// up to six multiplies lie outside the loop, and the Euclid loop dominates.
// Throughput: one transaction at a time; start is taken while busy is low.
// Reset: synchronous active-low; restores modulus and coefficient defaults.
// Results appear for one cycle with o_done high; the receiver cannot stall.
module montgomery_curve_point_add #(
    parameter int FIELD_BITS = mcpa_pkg::FIELD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mcpa_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [mcpa_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_first_inf,
    input  logic [63:0]                         i_first_x,
    input  logic [63:0]                         i_first_y,
    input  logic                                i_second_inf,
    input  logic [63:0]                         i_second_x,
    input  logic [63:0]                         i_second_y,
    output logic                                o_done,
    output logic                                o_sum_inf,
    output logic [63:0]                         o_sum_x,
    output logic [63:0]                         o_sum_y,
    output logic [1:0]                          o_status,
    output logic [63:0]                         o_factor
);
    import mcpa_pkg::*;

    localparam int W  = FIELD_BITS;
    localparam int RW = (W > A_BITS) ? W : A_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_RED, S_REDW, S_DECIDE,
        S_DBL1, S_DBL2, S_DBL3, S_DBL4, S_DBL5,
        S_INV0, S_INV1, S_INV2, S_INV3, S_INVE,
        S_FIN1, S_FIN2, S_FIN3, S_FIN4, S_FIN5, S_FIN6, S_FIN7, S_FIN8,
        S_MULW, S_DIVW
    } t_state;

    function automatic logic [W-1:0] fadd(logic [W-1:0] a, logic [W-1:0] b,
                                          logic [W-1:0] m);
        return W'(madd(t_word'(a), t_word'(b), t_word'(m)));
    endfunction

    function automatic logic [W-1:0] fsub(logic [W-1:0] a, logic [W-1:0] b,
                                          logic [W-1:0] m);
        return W'(msub(t_word'(a), t_word'(b), t_word'(m)));
    endfunction

    t_state r_state, r_ret;
    logic [2:0]        r_ridx;
    logic [W-1:0]      r_cfg_m;
    logic [A_BITS-1:0] r_cfg_a;
    logic              r_inf1, r_inf2;
    logic [W-1:0]      r_in_x1, r_in_y1, r_in_x2, r_in_y2;
    logic [W-1:0]      r_m, r_a, r_x1, r_y1, r_x2, r_y2;
    logic [W-1:0]      r_num, r_den, r_tmp;
    logic [W-1:0]      r_r0, r_r1, r_t0, r_t1, r_rem;
    logic [W-1:0]      r_s, r_s2, r_s3, r_x, r_lft, r_y;
    logic              r_mul_start, r_div_start;
    logic [W-1:0]      r_ma, r_mb;
    logic [RW-1:0]     r_dn;
    logic [W-1:0]      r_dd;

    logic              mul_done, div_done;
    logic [W-1:0]      mul_prod, div_rem;
    logic [RW-1:0]     div_quo;
    logic [W-1:0]      n_one, n_q, n_qm, n_ny2;

    assign n_one = (r_m == W'(1)) ? '0 : W'(1);
    assign n_q   = div_quo[W-1:0];
    assign n_qm  = (n_q >= r_m) ? n_q - r_m : n_q;
    assign n_ny2 = (r_y2 == '0) ? '0 : r_m - r_y2;
    assign busy  = (r_state != S_IDLE);

    mcpa_mul #(.W(W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_ma),
        .i_b     (r_mb),
        .i_m     (r_m),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    mcpa_div #(.DW(RW), .VW(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_dn),
        .i_den   (r_dd),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_ridx      <= '0;
            r_cfg_m     <= MODULUS_RST[W-1:0];
            r_cfg_a     <= COEF_A_RST;
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            o_done      <= 1'b0;
        end else begin
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            o_done      <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MODULUS: r_cfg_m <= i_cfg_data[W-1:0];
                    CFG_COEF_A:  r_cfg_a <= i_cfg_data[A_BITS-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_inf1  <= i_first_inf;
                        r_inf2  <= i_second_inf;
                        r_in_x1 <= i_first_x[W-1:0];
                        r_in_y1 <= i_first_y[W-1:0];
                        r_in_x2 <= i_second_x[W-1:0];
                        r_in_y2 <= i_second_y[W-1:0];
                        r_m     <= (r_cfg_m == '0) ? W'(1) : r_cfg_m;
                        r_ridx  <= '0;
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    case (r_ridx)
                        3'd0:    r_dn <= RW'(r_cfg_a);
                        3'd1:    r_dn <= RW'(r_in_x1);
                        3'd2:    r_dn <= RW'(r_in_y1);
                        3'd3:    r_dn <= RW'(r_in_x2);
                        default: r_dn <= RW'(r_in_y2);
                    endcase
                    r_dd        <= r_m;
                    r_div_start <= 1'b1;
                    r_state     <= S_REDW;
                end
                S_REDW: begin
                    if (div_done) begin
                        case (r_ridx)
                            3'd0:    r_a  <= div_rem;
                            3'd1:    r_x1 <= div_rem;
                            3'd2:    r_y1 <= div_rem;
                            3'd3:    r_x2 <= div_rem;
                            default: r_y2 <= div_rem;
                        endcase
                        r_ridx  <= r_ridx + 1'b1;
                        r_state <= (r_ridx == 3'd4) ? S_DECIDE : S_RED;
                    end
                end
                S_DECIDE: begin
                    o_sum_inf <= 1'b0;
                    o_sum_x   <= '0;
                    o_sum_y   <= '0;
                    o_status  <= ST_OK;
                    o_factor  <= '0;
                    if (r_inf1 || r_inf2) begin
                        o_done  <= 1'b1;
                        r_state <= S_IDLE;
                        if (r_inf1 && r_inf2) begin
                            o_sum_inf <= 1'b1;
                        end else if (r_inf1) begin
                            o_sum_x <= 64'(r_x2);
                            o_sum_y <= 64'(r_y2);
                        end else begin
                            o_sum_x <= 64'(r_x1);
                            o_sum_y <= 64'(r_y1);
                        end
                    end else if (r_x1 == r_x2 && r_y1 == r_y2) begin
                        if (r_y1 == '0) begin
                            o_sum_inf <= 1'b1;
                            o_done    <= 1'b1;
                            r_state   <= S_IDLE;
                        end else begin
                            r_ma        <= r_x1;
                            r_mb        <= r_x1;
                            r_mul_start <= 1'b1;
                            r_ret       <= S_DBL1;
                            r_state     <= S_MULW;
                        end
                    end else if (r_x1 == r_x2) begin
                        o_done  <= 1'b1;
                        r_state <= S_IDLE;
                        if (n_ny2 == r_y1) begin
                            o_sum_inf <= 1'b1;
                        end else begin
                            o_status <= ST_NOTCONJ;
                        end
                    end else begin
                        r_num   <= fsub(r_y2, r_y1, r_m);
                        r_den   <= fsub(r_x2, r_x1, r_m);
                        r_state <= S_INV0;
                    end
                end
                // numerator 3x^2 + 2Ax + 1, denominator 2y
                S_DBL1: begin
                    r_num   <= fadd(mul_prod, mul_prod, r_m);
                    r_tmp   <= mul_prod;
                    r_state <= S_DBL2;
                end
                S_DBL2: begin
                    r_num   <= fadd(r_num, r_tmp, r_m);
                    r_tmp   <= fadd(r_a, r_a, r_m);
                    r_state <= S_DBL3;
                end
                S_DBL3: begin
                    r_ma        <= r_x1;
                    r_mb        <= r_tmp;
                    r_mul_start <= 1'b1;
                    r_ret       <= S_DBL4;
                    r_state     <= S_MULW;
                end
                S_DBL4: begin
                    r_num   <= fadd(r_num, mul_prod, r_m);
                    r_state <= S_DBL5;
                end
                S_DBL5: begin
                    r_num   <= fadd(r_num, n_one, r_m);
                    r_den   <= fadd(r_y1, r_y1, r_m);
                    r_state <= S_INV0;
                end
                // extended Euclid on (m, den)
                S_INV0: begin
                    r_r0    <= r_m;
                    r_r1    <= r_den;
                    r_t0    <= '0;
                    r_t1    <= n_one;
                    r_state <= S_INV1;
                end
                S_INV1: begin
                    if (r_r1 == '0) begin
                        r_state <= S_INVE;
                    end else begin
                        r_dn        <= RW'(r_r0);
                        r_dd        <= r_r1;
                        r_div_start <= 1'b1;
                        r_ret       <= S_INV2;
                        r_state     <= S_DIVW;
                    end
                end
                S_INV2: begin
                    r_rem       <= div_rem;
                    r_ma        <= n_qm;
                    r_mb        <= r_t1;
                    r_mul_start <= 1'b1;
                    r_ret       <= S_INV3;
                    r_state     <= S_MULW;
                end
                S_INV3: begin
                    r_r0    <= r_r1;
                    r_r1    <= r_rem;
                    r_t0    <= r_t1;
                    r_t1    <= fsub(r_t0, mul_prod, r_m);
                    r_state <= S_INV1;
                end
                S_INVE: begin
                    if (r_r0 != W'(1)) begin
                        o_status <= ST_NOINV;
                        o_factor <= 64'(r_r0);
                        o_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_ma        <= r_num;
                        r_mb        <= r_t0;
                        r_mul_start <= 1'b1;
                        r_ret       <= S_FIN1;
                        r_state     <= S_MULW;
                    end
                end
                S_FIN1: begin
                    r_s         <= mul_prod;
                    r_ma        <= mul_prod;
                    r_mb        <= mul_prod;
                    r_mul_start <= 1'b1;
                    r_ret       <= S_FIN2;
                    r_state     <= S_MULW;
                end
                S_FIN2: begin
                    r_s2        <= mul_prod;
                    r_ma        <= mul_prod;
                    r_mb        <= r_s;
                    r_mul_start <= 1'b1;
                    r_ret       <= S_FIN3;
                    r_state     <= S_MULW;
                end
                S_FIN3: begin
                    r_s3    <= mul_prod;
                    r_x     <= fsub(r_s2, r_a, r_m);
                    r_lft   <= fadd(r_x1, r_x1, r_m);
                    r_state <= S_FIN4;
                end
                S_FIN4: begin
                    r_x     <= fsub(r_x, r_x1, r_m);
                    r_lft   <= fadd(r_lft, r_x2, r_m);
                    r_state <= S_FIN5;
                end
                S_FIN5: begin
                    r_x     <= fsub(r_x, r_x2, r_m);
                    r_lft   <= fadd(r_lft, r_a, r_m);
                    r_state <= S_FIN6;
                end
                S_FIN6: begin
                    r_ma        <= r_lft;
                    r_mb        <= r_s;
                    r_mul_start <= 1'b1;
                    r_ret       <= S_FIN7;
                    r_state     <= S_MULW;
                end
                S_FIN7: begin
                    r_y     <= fsub(mul_prod, r_s3, r_m);
                    r_state <= S_FIN8;
                end
                S_FIN8: begin
                    o_sum_x <= 64'(r_x);
                    o_sum_y <= 64'(fsub(r_y, r_y1, r_m));
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_MULW: begin
                    if (mul_done) begin
                        r_state <= r_ret;
                    end
                end
                S_DIVW: begin
                    if (div_done) begin
                        r_state <= r_ret;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_done_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without a transaction in flight");
    a_inf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_sum_inf |-> o_sum_x == '0 && o_sum_y == '0 && o_status == ST_OK)
        else $error("infinity result with nonzero fields");
    a_factor_only_noinv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != ST_NOINV |-> o_factor == '0)
        else $error("factor set without invertibility failure");
    a_factor_nontrivial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == ST_NOINV |-> o_factor != 64'd1 && o_sum_inf == 1'b0)
        else $error("invertibility failure with trivial gcd");

endmodule
